// ===== sv/rank_select_bit_vector_assert.svh =====
// ----------------------------------------------------------------------------
// rank_select_bit_vector_assert.svh
// Assertion macros for the rank/select bit vector RTL. They expect a
// clock named clock and an active-high synchronous reset named reset in scope.
// ----------------------------------------------------------------------------
`ifndef RANK_SELECT_BIT_VECTOR_ASSERT_SVH
`define RANK_SELECT_BIT_VECTOR_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define RSBV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define RSBV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rsbv_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbv_pkg
// Types, codes and helpers shared by the rank/select bit vector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsbv_pkg;

   // default geometry
   localparam int CAPACITY_BITS_DEF    = 65536;
   localparam int LARGE_BLOCK_BITS_DEF = 2048;
   localparam int SMALL_BLOCK_BITS     = 128;
   localparam int WORD_BITS            = 64;
   localparam int WORDS_PER_SMALL      = SMALL_BLOCK_BITS / WORD_BITS;

   // field widths
   localparam int MODE_W = 3;
   localparam int OPND_W = 17;

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FINALIZE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RANK     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SELECT   = 3'd4;

   // datapath commands
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
   localparam logic [OP_W-1:0] OP_CLR     = 5'd2;
   localparam logic [OP_W-1:0] OP_SET_RD  = 5'd3;
   localparam logic [OP_W-1:0] OP_SET_WR  = 5'd4;
   localparam logic [OP_W-1:0] OP_FIN_RD  = 5'd5;
   localparam logic [OP_W-1:0] OP_FIN_ACC = 5'd6;
   localparam logic [OP_W-1:0] OP_RANK_RD = 5'd7;
   localparam logic [OP_W-1:0] OP_RANK_A  = 5'd8;
   localparam logic [OP_W-1:0] OP_RANK_B  = 5'd9;
   localparam logic [OP_W-1:0] OP_LS_RD   = 5'd10;
   localparam logic [OP_W-1:0] OP_LS_CMP  = 5'd11;
   localparam logic [OP_W-1:0] OP_SS_INIT = 5'd12;
   localparam logic [OP_W-1:0] OP_SS_RD   = 5'd13;
   localparam logic [OP_W-1:0] OP_SS_CMP  = 5'd14;
   localparam logic [OP_W-1:0] OP_WD_INIT = 5'd15;
   localparam logic [OP_W-1:0] OP_WD_CHK  = 5'd16;
   localparam logic [OP_W-1:0] OP_WD_RD   = 5'd17;
   localparam logic [OP_W-1:0] OP_WS_STEP = 5'd18;
   localparam logic [OP_W-1:0] OP_RESULT  = 5'd19;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [OPND_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [OPND_W-1:0] answer;
      logic              error;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              err;
      logic              at_cap;
      logic              large_more;
      logic              small_more;
      logic              cnt_last;
      logic              ws_last;
      logic              rsp_free;
   } status_type;

   // population count of one word by field halving
   function automatic logic [6:0] pop64(input logic [63:0] w);
      logic [63:0] x;
      x = (w & 64'h5555555555555555) + ((w >> 1) & 64'h5555555555555555);
      x = (x & 64'h3333333333333333) + ((x >> 2) & 64'h3333333333333333);
      x = (x & 64'h0f0f0f0f0f0f0f0f) + ((x >> 4) & 64'h0f0f0f0f0f0f0f0f);
      x = (x & 64'h00ff00ff00ff00ff) + ((x >> 8) & 64'h00ff00ff00ff00ff);
      x = (x & 64'h0000ffff0000ffff) + ((x >> 16) & 64'h0000ffff0000ffff);
      x = (x & 64'h00000000ffffffff) + (x >> 32);
      return x[6:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/rsbv_ram.sv =====
// ----------------------------------------------------------------------------
// rsbv_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/rsbv_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsbv_ctrl
// Sequencer for the rank/select bit vector: walks each item through its
// datapath commands and holds off new items while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module rsbv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output rsbv_pkg::cmd_type    cmd,
   input  rsbv_pkg::status_type status
);
   import rsbv_pkg::*;

   localparam logic [4:0] S_CLR_BOOT = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_DISP     = 5'd2;
   localparam logic [4:0] S_CLR_ITEM = 5'd3;
   localparam logic [4:0] S_SET_RD   = 5'd4;
   localparam logic [4:0] S_SET_WR   = 5'd5;
   localparam logic [4:0] S_FIN_RD   = 5'd6;
   localparam logic [4:0] S_FIN_ACC  = 5'd7;
   localparam logic [4:0] S_RANK_RD  = 5'd8;
   localparam logic [4:0] S_RANK_A   = 5'd9;
   localparam logic [4:0] S_RANK_B   = 5'd10;
   localparam logic [4:0] S_LS_RD    = 5'd11;
   localparam logic [4:0] S_LS_CMP   = 5'd12;
   localparam logic [4:0] S_SS_INIT  = 5'd13;
   localparam logic [4:0] S_SS_RD    = 5'd14;
   localparam logic [4:0] S_SS_CMP   = 5'd15;
   localparam logic [4:0] S_WD_INIT  = 5'd16;
   localparam logic [4:0] S_WD_CHK   = 5'd17;
   localparam logic [4:0] S_WD_RD    = 5'd18;
   localparam logic [4:0] S_WS       = 5'd19;
   localparam logic [4:0] S_DONE     = 5'd20;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_CLR_BOOT: begin
            cmd.op = OP_CLR;
            if (status.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (status.mode)
               MODE_CLEAR:    state_in = S_CLR_ITEM;
               MODE_SET:      state_in = status.err ? S_DONE : S_SET_RD;
               MODE_FINALIZE: state_in = S_FIN_RD;
               MODE_RANK:     state_in = (status.err || status.at_cap) ? S_DONE : S_RANK_RD;
               MODE_SELECT:   state_in = status.err ? S_DONE : S_LS_RD;
               default:       state_in = S_DONE;
            endcase
         end
         S_CLR_ITEM: begin
            cmd.op = OP_CLR;
            if (status.cnt_last) state_in = S_DONE;
         end
         S_SET_RD: begin
            cmd.op   = OP_SET_RD;
            state_in = S_SET_WR;
         end
         S_SET_WR: begin
            cmd.op   = OP_SET_WR;
            state_in = S_DONE;
         end
         S_FIN_RD: begin
            cmd.op   = OP_FIN_RD;
            state_in = S_FIN_ACC;
         end
         S_FIN_ACC: begin
            cmd.op   = OP_FIN_ACC;
            state_in = status.cnt_last ? S_DONE : S_FIN_RD;
         end
         S_RANK_RD: begin
            cmd.op   = OP_RANK_RD;
            state_in = S_RANK_A;
         end
         S_RANK_A: begin
            cmd.op   = OP_RANK_A;
            state_in = S_RANK_B;
         end
         S_RANK_B: begin
            cmd.op   = OP_RANK_B;
            state_in = S_DONE;
         end
         S_LS_RD: begin
            if (status.large_more) begin
               cmd.op   = OP_LS_RD;
               state_in = S_LS_CMP;
            end else begin
               state_in = S_SS_INIT;
            end
         end
         S_LS_CMP: begin
            cmd.op   = OP_LS_CMP;
            state_in = S_LS_RD;
         end
         S_SS_INIT: begin
            cmd.op   = OP_SS_INIT;
            state_in = S_SS_RD;
         end
         S_SS_RD: begin
            if (status.small_more) begin
               cmd.op   = OP_SS_RD;
               state_in = S_SS_CMP;
            end else begin
               state_in = S_WD_INIT;
            end
         end
         S_SS_CMP: begin
            cmd.op   = OP_SS_CMP;
            state_in = S_SS_RD;
         end
         S_WD_INIT: begin
            cmd.op   = OP_WD_INIT;
            state_in = S_WD_CHK;
         end
         S_WD_CHK: begin
            cmd.op   = OP_WD_CHK;
            state_in = S_WD_RD;
         end
         S_WD_RD: begin
            cmd.op   = OP_WD_RD;
            state_in = S_WS;
         end
         S_WS: begin
            cmd.op = OP_WS_STEP;
            if (status.ws_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLR_BOOT;
      endcase
   end

   // state register, clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/rsbv_dpath.sv =====
// ----------------------------------------------------------------------------
// rsbv_dpath
// Datapath: bit word memory, large and small count directories, search
// registers, popcount and in-word select, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rank_select_bit_vector_assert.svh"

module rsbv_dpath #(
   parameter int CAPACITY_BITS    = rsbv_pkg::CAPACITY_BITS_DEF,
   parameter int LARGE_BLOCK_BITS = rsbv_pkg::LARGE_BLOCK_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsbv_pkg::cmd_type    cmd,
   output rsbv_pkg::status_type status,
   input  rsbv_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsbv_pkg::rsp_type    rsp_data
);
   import rsbv_pkg::*;

   localparam int SPL       = LARGE_BLOCK_BITS / SMALL_BLOCK_BITS;
   localparam int NUM_LARGE = (CAPACITY_BITS + LARGE_BLOCK_BITS - 1) / LARGE_BLOCK_BITS;
   localparam int NUM_SMALL = NUM_LARGE * SPL;
   localparam int NUM_WORDS = NUM_SMALL * WORDS_PER_SMALL;
   localparam int WADDR_W   = $clog2(NUM_WORDS);
   localparam int SADDR_W   = $clog2(NUM_SMALL);
   localparam int LADDR_W   = (NUM_LARGE > 1) ? $clog2(NUM_LARGE) : 1;
   localparam int SPL_SH    = $clog2(SPL);
   localparam int LB_SH     = $clog2(LARGE_BLOCK_BITS);
   localparam int CNT_W     = $clog2(CAPACITY_BITS + 1);
   localparam int SCNT_W    = $clog2(LARGE_BLOCK_BITS);
   localparam int IL_W      = $clog2(LARGE_BLOCK_BITS + 1);
   localparam int KW        = (CNT_W > OPND_W) ? CNT_W : OPND_W;
   localparam int LI_W      = LADDR_W + 1;
   localparam int SI_W      = SADDR_W + 1;
   localparam int PW        = WADDR_W + 6;

   // item registers
   logic [MODE_W-1:0]  mode_ff,  mode_in;
   logic [OPND_W-1:0]  opnd_ff,  opnd_in;
   logic [OPND_W-1:0]  k_ff,     k_in;
   logic [KW-1:0]      acc_ff,   acc_in;
   logic               err_ff,   err_in;
   // sweep and directory build
   logic [WADDR_W-1:0] cnt_ff,   cnt_in;
   logic [CNT_W-1:0]   run_ff,   run_in;
   logic [IL_W-1:0]    il_ff,    il_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   // binary searches
   logic [LI_W-1:0]    llo_ff,   llo_in;
   logic [LI_W-1:0]    lhi_ff,   lhi_in;
   logic [CNT_W-1:0]   lval_ff,  lval_in;
   logic [SI_W-1:0]    slo_ff,   slo_in;
   logic [SI_W-1:0]    shi_ff,   shi_in;
   logic [SCNT_W-1:0]  sval_ff,  sval_in;
   // word choice and in-word select
   logic [WADDR_W-1:0] w_ff,     w_in;
   logic [5:0]         bpos_ff,  bpos_in;
   logic [2:0]         lvl_ff,   lvl_in;
   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,       rsp_in;

   // memory ports
   logic                 bw_we, bw_re;
   logic [WADDR_W-1:0]   bw_addr;
   logic [WORD_BITS-1:0] bw_wdata, bw_rdata;
   logic                 lc_we, lc_re;
   logic [LADDR_W-1:0]   lc_addr;
   logic [CNT_W-1:0]     lc_wdata, lc_rdata;
   logic                 sc_we, sc_re;
   logic [SADDR_W-1:0]   sc_addr;
   logic [SCNT_W-1:0]    sc_wdata, sc_rdata;

   // helpers
   logic [KW-1:0]        opx;
   logic [KW-1:0]        req_opx;
   logic [LI_W:0]        lsum;
   logic [SI_W:0]        ssum;
   logic [SADDR_W-1:0]   fin_small;
   logic [6:0]           word_pop;
   logic [6:0]           masked_pop;
   logic [6:0]           field_pop;
   logic [6:0]           half;
   logic [WORD_BITS-1:0] field;
   logic [PW-1:0]        sel_pos;
   logic                 rsp_free;

   assign opx        = KW'(opnd_ff);
   assign req_opx    = KW'(req_data.operand);
   assign lsum       = {1'b0, llo_ff} + {1'b0, lhi_ff};
   assign ssum       = {1'b0, slo_ff} + {1'b0, shi_ff};
   assign fin_small  = SADDR_W'(cnt_ff >> 1);
   assign word_pop   = pop64(bw_rdata);
   assign masked_pop = pop64(bw_rdata & ((64'd1 << opnd_ff[5:0]) - 64'd1));
   assign half       = 7'd1 << lvl_ff;
   assign field      = (bw_rdata >> bpos_ff) & ((64'd1 << half) - 64'd1);
   assign field_pop  = pop64(field);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // command decode
   always_comb begin
      mode_in      = mode_ff;
      opnd_in      = opnd_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      il_in        = il_ff;
      total_in     = total_ff;
      llo_in       = llo_ff;
      lhi_in       = lhi_ff;
      lval_in      = lval_ff;
      slo_in       = slo_ff;
      shi_in       = shi_ff;
      sval_in      = sval_ff;
      w_in         = w_ff;
      bpos_in      = bpos_ff;
      lvl_in       = lvl_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sel_pos      = {w_ff, bpos_ff};
      bw_we        = 1'b0;
      bw_re        = 1'b0;
      bw_addr      = cnt_ff;
      bw_wdata     = '0;
      lc_we        = 1'b0;
      lc_re        = 1'b0;
      lc_addr      = '0;
      lc_wdata     = '0;
      sc_we        = 1'b0;
      sc_re        = 1'b0;
      sc_addr      = fin_small;
      sc_wdata     = '0;
      case (cmd.op)
         OP_LOAD: begin
            mode_in = req_data.mode;
            opnd_in = req_data.operand;
            k_in    = req_data.operand;
            acc_in  = '0;
            err_in  = 1'b0;
            cnt_in  = '0;
            run_in  = '0;
            il_in   = '0;
            llo_in  = '0;
            lhi_in  = LI_W'(NUM_LARGE);
            lval_in = '0;
            case (req_data.mode)
               MODE_SET: err_in = (req_opx >= KW'(CAPACITY_BITS));
               MODE_RANK: begin
                  err_in = (req_opx > KW'(CAPACITY_BITS));
                  if (req_opx == KW'(CAPACITY_BITS)) acc_in = KW'(total_ff);
               end
               MODE_SELECT: err_in = (req_data.operand == '0) ||
                                     (req_opx > KW'(total_ff));
               default: err_in = 1'b0;
            endcase
         end
         // zero one word and its directory entries
         OP_CLR: begin
            bw_we    = 1'b1;
            sc_we    = 1'b1;
            lc_we    = 1'b1;
            lc_addr  = LADDR_W'(cnt_ff >> (SPL_SH + 1));
            total_in = '0;
            cnt_in   = cnt_ff + 1'b1;
         end
         OP_SET_RD: begin
            bw_re   = 1'b1;
            bw_addr = opx[6 +: WADDR_W];
         end
         OP_SET_WR: begin
            bw_we    = 1'b1;
            bw_addr  = opx[6 +: WADDR_W];
            bw_wdata = bw_rdata | (64'd1 << opnd_ff[5:0]);
         end
         // read a word; on a small block start write its directory entries
         OP_FIN_RD: begin
            bw_re = 1'b1;
            if (!cnt_ff[0]) begin
               sc_we = 1'b1;
               if (fin_small[SPL_SH-1:0] == '0) begin
                  lc_we    = 1'b1;
                  lc_addr  = LADDR_W'(fin_small >> SPL_SH);
                  lc_wdata = run_ff;
                  sc_wdata = '0;
                  il_in    = '0;
               end else begin
                  sc_wdata = SCNT_W'(il_ff);
               end
            end
         end
         OP_FIN_ACC: begin
            run_in = run_ff + CNT_W'(word_pop);
            il_in  = il_ff + IL_W'(word_pop);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WADDR_W'(NUM_WORDS - 1)) total_in = run_in;
         end
         OP_RANK_RD: begin
            bw_re   = 1'b1;
            bw_addr = opx[6 +: WADDR_W];
            lc_re   = 1'b1;
            lc_addr = LADDR_W'(opx >> LB_SH);
            sc_re   = 1'b1;
            sc_addr = opx[7 +: SADDR_W];
         end
         // directories plus the partial word, then fetch the even word
         OP_RANK_A: begin
            acc_in  = KW'(lc_rdata) + KW'(sc_rdata) + KW'(masked_pop);
            bw_re   = 1'b1;
            bw_addr = {opx[7 +: WADDR_W-1], 1'b0};
         end
         OP_RANK_B: begin
            if (opx[6]) acc_in = acc_ff + KW'(word_pop);
         end
         OP_LS_RD: begin
            lc_re   = 1'b1;
            lc_addr = LADDR_W'(lsum >> 1);
         end
         OP_LS_CMP: begin
            if (KW'(lc_rdata) < KW'(k_ff)) begin
               llo_in  = LI_W'(lsum >> 1);
               lval_in = lc_rdata;
            end else begin
               lhi_in = LI_W'(lsum >> 1);
            end
         end
         OP_SS_INIT: begin
            k_in    = k_ff - OPND_W'(lval_ff);
            slo_in  = SI_W'(llo_ff) << SPL_SH;
            shi_in  = (SI_W'(llo_ff) << SPL_SH) + SI_W'(SPL);
            sval_in = '0;
         end
         OP_SS_RD: begin
            sc_re   = 1'b1;
            sc_addr = SADDR_W'(ssum >> 1);
         end
         OP_SS_CMP: begin
            if (OPND_W'(sc_rdata) < k_ff) begin
               slo_in  = SI_W'(ssum >> 1);
               sval_in = sc_rdata;
            end else begin
               shi_in = SI_W'(ssum >> 1);
            end
         end
         OP_WD_INIT: begin
            k_in    = k_ff - OPND_W'(sval_ff);
            w_in    = {SADDR_W'(slo_ff), 1'b0};
            bw_re   = 1'b1;
            bw_addr = {SADDR_W'(slo_ff), 1'b0};
         end
         // step past the even word when it holds too few ones
         OP_WD_CHK: begin
            if (OPND_W'(word_pop) < k_ff) begin
               k_in = k_ff - OPND_W'(word_pop);
               w_in = w_ff + 1'b1;
            end
            bpos_in = '0;
            lvl_in  = 3'd5;
         end
         OP_WD_RD: begin
            bw_re   = 1'b1;
            bw_addr = w_ff;
         end
         // one halving level of the in-word select
         OP_WS_STEP: begin
            if (OPND_W'(field_pop) < k_ff) begin
               k_in    = k_ff - OPND_W'(field_pop);
               bpos_in = bpos_ff | half[5:0];
            end
            lvl_in  = lvl_ff - 1'b1;
            sel_pos = {w_ff, bpos_in};
            if (lvl_ff == '0) acc_in = KW'(sel_pos);
         end
         OP_RESULT: begin
            rsp_in.answer = OPND_W'(acc_ff);
            rsp_in.error  = err_ff;
            rsp_valid_in  = 1'b1;
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      opnd_ff <= opnd_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      err_ff  <= err_in;
      run_ff  <= run_in;
      il_ff   <= il_in;
      llo_ff  <= llo_in;
      lhi_ff  <= lhi_in;
      lval_ff <= lval_in;
      slo_ff  <= slo_in;
      shi_ff  <= shi_in;
      sval_ff <= sval_in;
      w_ff    <= w_in;
      bpos_ff <= bpos_in;
      lvl_ff  <= lvl_in;
      rsp_ff  <= rsp_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rsbv_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_bit_words (
      .clock (clock),
      .we    (bw_we),
      .re    (bw_re),
      .addr  (bw_addr),
      .wdata (bw_wdata),
      .rdata (bw_rdata)
   );

   rsbv_ram #(.WIDTH(CNT_W), .DEPTH(NUM_LARGE)) u_large_counts (
      .clock (clock),
      .we    (lc_we),
      .re    (lc_re),
      .addr  (lc_addr),
      .wdata (lc_wdata),
      .rdata (lc_rdata)
   );

   rsbv_ram #(.WIDTH(SCNT_W), .DEPTH(NUM_SMALL)) u_small_counts (
      .clock (clock),
      .we    (sc_we),
      .re    (sc_re),
      .addr  (sc_addr),
      .wdata (sc_wdata),
      .rdata (sc_rdata)
   );

   // status to the sequencer
   assign status.mode       = mode_ff;
   assign status.err        = err_ff;
   assign status.at_cap     = (opx == KW'(CAPACITY_BITS));
   assign status.large_more = ((lhi_ff - llo_ff) > LI_W'(1));
   assign status.small_more = ((shi_ff - slo_ff) > SI_W'(1));
   assign status.cnt_last   = (cnt_ff == WADDR_W'(NUM_WORDS - 1));
   assign status.ws_last    = (lvl_ff == '0);
   assign status.rsp_free   = rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RSBV_ASSERT_NOW(a_result_slot_free, cmd.op == OP_RESULT, rsp_free, "result over a held transfer")
   `RSBV_ASSERT_NEXT(a_small_span, cmd.op == OP_SS_INIT, (shi_ff - slo_ff) == SI_W'(SPL), "bad small search span")
   `RSBV_ASSERT_NOW(a_large_probe, cmd.op == OP_LS_RD, lhi_ff > llo_ff, "large probe outside span")
   `RSBV_ASSERT_NOW(a_error_zero, rsp_valid_ff && rsp_ff.error, rsp_ff.answer == '0, "error with nonzero answer")

endmodule

`default_nettype wire

// ===== sv/rank_select_bit_vector.sv =====
// ----------------------------------------------------------------------------
// rank_select_bit_vector
// Bit vector with a two-level rank directory: clear, set, finalize, rank and
// select, one result transfer per request transfer.
// ----------------------------------------------------------------------------
//  channel  ports                          payload
//  request  req_valid / req_stall          req_data  (mode, operand)
//  result   rsp_valid / rsp_stall          rsp_data  (answer, error)
//
//  Set, rank and select are paced by the single-port word and directory
//  memories; select also runs a search of the large, then of the small
//  count directory, and the six-level in-word select.
//  Finalize reads every word.
//  Clear and reset both zero the memories one word per cycle; req_stall
//  stays high through that pass.
//  A new request transfer is taken while the last result still waits on
//  rsp_stall; the next result waits in turn until that slot drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_select_bit_vector #(
   parameter int CAPACITY_BITS    = rsbv_pkg::CAPACITY_BITS_DEF,
   parameter int LARGE_BLOCK_BITS = rsbv_pkg::LARGE_BLOCK_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsbv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsbv_pkg::rsp_type rsp_data
);
   import rsbv_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   rsbv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // memories and arithmetic
   rsbv_dpath #(
      .CAPACITY_BITS    (CAPACITY_BITS),
      .LARGE_BLOCK_BITS (LARGE_BLOCK_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
